// File: src/frx_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the checked frame receiver.
// No dependencies; imported by frx_front, frx_back, checked_frame_receiver and frx_checker.
package frx_pkg;

    // Result status codes
    localparam logic [2:0] ST_IGNORED = 3'd0;
    localparam logic [2:0] ST_STEP    = 3'd1;
    localparam logic [2:0] ST_SUM_ERR = 3'd2;
    localparam logic [2:0] ST_XOR_ERR = 3'd3;
    localparam logic [2:0] ST_GOOD    = 3'd4;

    // Configuration register indexes
    localparam int         CFG_IDX_W    = 2;
    localparam logic [1:0] CFG_HDR_FIRST  = 2'd0;
    localparam logic [1:0] CFG_HDR_SECOND = 2'd1;
    localparam logic [1:0] CFG_PAY_LEN    = 2'd2;

    localparam logic [7:0] HDR_FIRST_RST  = 8'h55;
    localparam logic [7:0] HDR_SECOND_RST = 8'hAA;
    localparam logic [3:0] PAY_LEN_RST    = 4'd3;

    // Work handed from the parser to the result side
    typedef enum logic [1:0] {
        OP_RESULT  = 2'd0,  // single status result
        OP_STORE   = 2'd1,  // store a payload byte, then a step result
        OP_READOUT = 2'd2   // read out the stored payload of a good frame
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [2:0] status;
        logic [7:0] data;
    } t_cmd;

endpackage

// File: src/frx_if.sv
`timescale 1ns / 1ps
// Handshake channels of the checked frame receiver: received bytes in,
// status and payload results out. No dependencies.
interface frx_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface frx_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic       ack;
    logic [7:0] payload_byte;
    logic [2:0] payload_index;
    logic       last;

    modport source (output valid, output status, output ack, output payload_byte,
                    output payload_index, output last, input ready);
    modport sink   (input valid, input status, input ack, input payload_byte,
                    input payload_index, input last, output ready);
endinterface

// File: src/frx_front.sv
`timescale 1ns / 1ps
// Parser front end: holds the configuration registers, hunts for the header,
// tracks payload count, sum and XOR, and issues one command per byte.
// Depends on frx_pkg and frx_byte_if.
module frx_front import frx_pkg::*; #(
    parameter int MAX_PAYLOAD = 8,
    parameter int CNT_W       = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    frx_byte_if.sink             rx,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]           i_cfg_data,
    input  logic                 i_full,
    output logic                 o_push,
    output t_cmd                 o_cmd,
    output logic [CNT_W-1:0]     o_cmd_cnt
);

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_HDR2    = 3'd1,
        PH_PAYLOAD = 3'd2,
        PH_SUM     = 3'd3,
        PH_XOR     = 3'd4
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [7:0]       r_sum, n_sum;
    logic [7:0]       r_xor, n_xor;
    logic [7:0]       r_hdr1, r_hdr2;
    logic [3:0]       r_len;

    logic             accept;
    logic [7:0]       b;
    logic [CNT_W-1:0] eff_len;
    logic [CNT_W-1:0] cnt_inc;

    assign rx.ready = !i_full;
    assign accept   = rx.valid && !i_full;
    assign o_push   = accept;
    assign b        = rx.rx_byte;

    // Clamp the length register to 1..MAX_PAYLOAD
    always_comb begin
        if (r_len == 4'd0) begin
            eff_len = CNT_W'(1);
        end else if (32'(r_len) > 32'(MAX_PAYLOAD)) begin
            eff_len = CNT_W'(MAX_PAYLOAD);
        end else begin
            eff_len = CNT_W'(r_len);
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_cnt      = r_cnt;
        n_sum      = r_sum;
        n_xor      = r_xor;
        cnt_inc    = r_cnt;
        o_cmd.op     = OP_RESULT;
        o_cmd.status = ST_IGNORED;
        o_cmd.data   = 8'd0;
        o_cmd_cnt    = '0;
        case (r_phase)
            PH_HDR2: begin
                if (b == r_hdr2) begin
                    n_phase      = PH_PAYLOAD;
                    n_cnt        = '0;
                    n_sum        = 8'd0;
                    n_xor        = 8'd0;
                    o_cmd.status = ST_STEP;
                end else begin
                    n_phase = PH_HUNT;
                end
            end
            PH_PAYLOAD: begin
                o_cmd.status = ST_STEP;
                if (r_cnt < CNT_W'(MAX_PAYLOAD)) begin
                    n_sum      = r_sum + b;
                    n_xor      = r_xor ^ b;
                    o_cmd.op   = OP_STORE;
                    o_cmd.data = b;
                    o_cmd_cnt  = r_cnt;
                    cnt_inc    = r_cnt + CNT_W'(1);
                end
                n_cnt = cnt_inc;
                if (cnt_inc >= eff_len) begin
                    n_phase = PH_SUM;
                end
            end
            PH_SUM: begin
                if (b == r_sum) begin
                    n_phase      = PH_XOR;
                    o_cmd.status = ST_STEP;
                end else begin
                    n_phase      = PH_HUNT;
                    n_cnt        = '0;
                    n_sum        = 8'd0;
                    n_xor        = 8'd0;
                    o_cmd.status = ST_SUM_ERR;
                end
            end
            PH_XOR: begin
                if (b == r_xor && r_cnt != '0) begin
                    o_cmd.op     = OP_READOUT;
                    o_cmd.status = ST_GOOD;
                    o_cmd_cnt    = r_cnt;
                end else begin
                    o_cmd.status = ST_XOR_ERR;
                end
                n_phase = PH_HUNT;
                n_cnt   = '0;
                n_sum   = 8'd0;
                n_xor   = 8'd0;
            end
            default: begin
                if (b == r_hdr1) begin
                    n_phase      = PH_HDR2;
                    o_cmd.status = ST_STEP;
                end else begin
                    n_phase = PH_HUNT;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_cnt   <= '0;
            r_sum   <= 8'd0;
            r_xor   <= 8'd0;
            r_hdr1  <= HDR_FIRST_RST;
            r_hdr2  <= HDR_SECOND_RST;
            r_len   <= PAY_LEN_RST;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_HDR_FIRST:  r_hdr1 <= i_cfg_data;
                    CFG_HDR_SECOND: r_hdr2 <= i_cfg_data;
                    CFG_PAY_LEN:    r_len  <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (accept) begin
                r_phase <= n_phase;
                r_cnt   <= n_cnt;
                r_sum   <= n_sum;
                r_xor   <= n_xor;
            end
        end
    end

endmodule

// File: src/frx_queue.sv
`timescale 1ns / 1ps
// Four-entry command queue between the parser and the result side.
// Depends on nothing; payload width set by parameter.
module frx_queue #(
    parameter int WIDTH = 17
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int DEPTH = 4;
    localparam int PTR_W = 2;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [PTR_W:0]   r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == (PTR_W+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + (PTR_W+1)'(1);
                2'b01:   r_count <= r_count - (PTR_W+1)'(1);
                default: ;
            endcase
        end
    end

endmodule

// File: src/frx_back.sv
`timescale 1ns / 1ps
// Result side: holds the payload store, turns queued commands into results
// and reads out a good frame one byte a cycle, unless res.ready stalls it, into the output register.
// Depends on frx_pkg and frx_result_if.
module frx_back import frx_pkg::*; #(
    parameter int MAX_PAYLOAD = 8,
    parameter int CNT_W       = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_head_valid,
    input  t_cmd             i_head,
    input  logic [CNT_W-1:0] i_head_cnt,
    output logic             o_pop,
    frx_result_if.source     res
);

    localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    logic [7:0]       r_store [MAX_PAYLOAD];
    logic [7:0]       r_rd_data;
    logic [IDX_W-1:0] r_idx, n_idx;

    logic             r_valid, n_valid;
    logic [2:0]       r_status, n_status;
    logic             r_ack, n_ack;
    logic [7:0]       r_byte, n_byte;
    logic [2:0]       r_index, n_index;
    logic             r_last, n_last;

    logic             load;
    logic             store_we;
    logic [CNT_W-1:0] idx_next;

    assign load     = !r_valid || res.ready;
    assign idx_next = CNT_W'(r_idx) + CNT_W'(1);

    always_comb begin
        n_idx    = r_idx;
        o_pop    = 1'b0;
        store_we = 1'b0;
        n_valid  = r_valid && !res.ready;
        n_status = r_status;
        n_ack    = r_ack;
        n_byte   = r_byte;
        n_index  = r_index;
        n_last   = r_last;
        if (i_head_valid && load) begin
            n_valid = 1'b1;
            case (i_head.op)
                OP_READOUT: begin
                    n_status = ST_GOOD;
                    n_ack    = 1'b1;
                    n_byte   = r_rd_data;
                    n_index  = 3'(r_idx);
                    n_last   = (idx_next == i_head_cnt);
                    if (idx_next == i_head_cnt) begin
                        o_pop = 1'b1;
                        n_idx = '0;
                    end else begin
                        n_idx = IDX_W'(idx_next);
                    end
                end
                default: begin
                    store_we = (i_head.op == OP_STORE);
                    n_status = i_head.status;
                    n_ack    = (i_head.status == ST_STEP) || (i_head.status == ST_GOOD);
                    n_byte   = 8'd0;
                    n_index  = 3'd0;
                    n_last   = 1'b1;
                    o_pop    = 1'b1;
                end
            endcase
        end
    end

    // Prefetch the entry to be shown next; idle address stays at entry zero
    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[i_head_cnt[IDX_W-1:0]] <= i_head.data;
        end
        r_rd_data <= r_store[n_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
        r_status <= n_status;
        r_ack    <= n_ack;
        r_byte   <= n_byte;
        r_index  <= n_index;
        r_last   <= n_last;
    end

    assign res.valid         = r_valid;
    assign res.status        = r_status;
    assign res.ack           = r_ack;
    assign res.payload_byte  = r_byte;
    assign res.payload_index = r_index;
    assign res.last          = r_last;

endmodule

// File: src/checked_frame_receiver.sv
`timescale 1ns / 1ps
// Checked frame receiver: header hunt, payload sum/XOR check, payload readout.
// An accepted byte's command is written into the queue, then registered into the output register.
// Throughput: one byte and one result per cycle while the result side is ready; a good
// frame of n payload bytes yields 2n+3 results for n+4 bytes; the four-entry queue fills and input stalls.
// Reset (synchronous, active low) clears parser, queue and output register and
// restores headers 0x55/0xAA and payload length 3; the payload store is not cleared.
module checked_frame_receiver import frx_pkg::*; #(
    parameter int MAX_PAYLOAD = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    frx_byte_if.sink             i_rx,
    frx_result_if.source         o_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]           i_cfg_data
);

    localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
    localparam int Q_W   = $bits(t_cmd) + CNT_W;

    logic             push, pop, full, empty;
    t_cmd             cmd, head;
    logic [CNT_W-1:0] cmd_cnt, head_cnt;
    logic [Q_W-1:0]   q_out;

    frx_front #(.MAX_PAYLOAD(MAX_PAYLOAD), .CNT_W(CNT_W)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .rx         (i_rx),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_full     (full),
        .o_push     (push),
        .o_cmd      (cmd),
        .o_cmd_cnt  (cmd_cnt)
    );

    frx_queue #(.WIDTH(Q_W)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({cmd, cmd_cnt}),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_data  (q_out)
    );

    assign head     = t_cmd'(q_out[Q_W-1:CNT_W]);
    assign head_cnt = q_out[CNT_W-1:0];

    frx_back #(.MAX_PAYLOAD(MAX_PAYLOAD), .CNT_W(CNT_W)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (!empty),
        .i_head       (head),
        .i_head_cnt   (head_cnt),
        .o_pop        (pop),
        .res          (o_res)
    );

endmodule

// File: src/frx_checker.sv
`timescale 1ns / 1ps
// Port-level checks on the result channel of the checked frame receiver.
// Depends on frx_pkg; bound to checked_frame_receiver below.
module frx_prop_checker import frx_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       i_ready,
    input logic [2:0] i_status,
    input logic       i_ack,
    input logic [7:0] i_byte,
    input logic [2:0] i_index,
    input logic       i_last
);

    // Output register empties on reset
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !i_valid)
        else $error("result valid after reset");

    // Hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_status) && $stable(i_byte)
            && $stable(i_index) && $stable(i_last))
        else $error("stalled result changed");

    // Acknowledge only on step and good, payload fields zero otherwise
    a_ack_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_ack == (i_status == ST_STEP || i_status == ST_GOOD))
            && (i_status == ST_GOOD || (i_byte == 8'd0 && i_index == 3'd0 && i_last)))
        else $error("inconsistent ack or payload fields");

    // Readout continues with the next index
    a_readout_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_ready && i_status == ST_GOOD && !i_last |=>
            !i_valid || (i_status == ST_GOOD && i_index == 3'($past(i_index) + 3'd1)))
        else $error("payload readout out of order");

endmodule

bind checked_frame_receiver frx_prop_checker u_frx_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (o_res.valid),
    .i_ready  (o_res.ready),
    .i_status (o_res.status),
    .i_ack    (o_res.ack),
    .i_byte   (o_res.payload_byte),
    .i_index  (o_res.payload_index),
    .i_last   (o_res.last)
);
